// ===== design/sbrm_pkg.sv =====
// sbrm_pkg: shared types, constants and event codes of the seat belt row monitor.
// No dependencies; imported by every module of the block.
package sbrm_pkg;

    localparam int ROWS_DEF    = 7;
    localparam int QDEPTH_DEF  = 4;
    localparam int SEATS       = 4;
    localparam int TYPES       = 3;
    localparam int NPOS        = SEATS * TYPES;
    localparam int ROW_W       = 3;
    localparam int CNT_W       = 4;

    localparam logic [2:0] EV_REPORT     = 3'd0;
    localparam logic [2:0] EV_RAISE_BASE = 3'd1;
    localparam logic [2:0] EV_CLEAR_BASE = 3'd4;

    // one classified row report; bit position is seat * TYPES + type
    typedef struct packed {
        logic [ROW_W-1:0] rix;
        logic [NPOS-1:0]  change;
        logic [NPOS-1:0]  now;
        logic [7:0]       colours;
        logic [3:0]       seats;
        logic [3:0]       buckled;
        logic [3:0]       eff;
        logic             door;
        logic             syserr;
        logic             alarm;
        logic [CNT_W-1:0] raised_cnt;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

// ===== design/seat_belt_row_monitor.sv =====
// seat_belt_row_monitor: top level joining front, queue and back of the row monitor.
// An accepted report is written into the queue; the back registers results from its head.
// A report with N changed error bits (0..12) gives N event results, then the row report,
// one result per cycle while out_stall is low; freeze and out-of-range rows are not queued.
// Reset: all error masks, live and saved pins clear, pins unfrozen, queue and output empty.
// Depends on sbrm_pkg, sbrm_front, sbrm_queue, sbrm_back.
module seat_belt_row_monitor #(
    parameter int ROWS   = sbrm_pkg::ROWS_DEF,
    parameter int QDEPTH = sbrm_pkg::QDEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      func,
    input  logic [sbrm_pkg::ROW_W-1:0] row,
    input  logic [3:0]                seat_empty,
    input  logic [3:0]                belt_mask,
    input  logic [3:0]                status_pins,
    input  logic                      door_open,
    input  logic                      system_error,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                event_res,
    output logic [sbrm_pkg::ROW_W-1:0] row_index,
    output logic [1:0]                seat_index,
    output logic [7:0]                seat_colours,
    output logic [3:0]                occupied_raw,
    output logic [3:0]                buckled_bits,
    output logic [3:0]                status_used,
    output logic                      door_flag,
    output logic                      error_code,
    output logic                      unbuckled_alarm,
    output logic [sbrm_pkg::CNT_W-1:0] new_error_count,
    output logic                      last
);
    import sbrm_pkg::*;

    job_t   wjob;
    job_t   head;
    qstat_t qstat;
    logic   push;
    logic   pop;

    sbrm_front #(.ROWS(ROWS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .row          (row),
        .seat_empty   (seat_empty),
        .belt_mask    (belt_mask),
        .status_pins  (status_pins),
        .door_open    (door_open),
        .system_error (system_error),
        .qstat        (qstat),
        .push         (push),
        .job          (wjob)
    );

    sbrm_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wjob),
        .pop   (pop),
        .head  (head),
        .qstat (qstat)
    );

    sbrm_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .qstat           (qstat),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .event_res       (event_res),
        .row_index       (row_index),
        .seat_index      (seat_index),
        .seat_colours    (seat_colours),
        .occupied_raw    (occupied_raw),
        .buckled_bits    (buckled_bits),
        .status_used     (status_used),
        .door_flag       (door_flag),
        .error_code      (error_code),
        .unbuckled_alarm (unbuckled_alarm),
        .new_error_count (new_error_count),
        .last            (last)
    );

endmodule

// ===== design/sbrm_front.sv =====
// sbrm_front: accepts input transfers, keeps per-row masks and pins, classifies reports.
// Depends on sbrm_pkg.
module sbrm_front #(
    parameter int ROWS = sbrm_pkg::ROWS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      func,
    input  logic [sbrm_pkg::ROW_W-1:0] row,
    input  logic [3:0]                seat_empty,
    input  logic [3:0]                belt_mask,
    input  logic [3:0]                status_pins,
    input  logic                      door_open,
    input  logic                      system_error,
    input  sbrm_pkg::qstat_t          qstat,
    output logic                      push,
    output sbrm_pkg::job_t            job
);
    import sbrm_pkg::*;

    localparam int RIX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ROW_W:0] ROWS_L = (ROW_W+1)'(ROWS);

    logic [3:0] live_reg  [ROWS];
    logic [3:0] saved_reg [ROWS];
    logic [3:0] bes_reg   [ROWS];
    logic [3:0] oi_reg    [ROWS];
    logic [3:0] bi_reg    [ROWS];
    logic       frozen_reg;

    logic             accept;
    logic             row_ok;
    logic [ROW_W-1:0] rix;
    logic [RIX_W-1:0] idx;
    logic [3:0]       buckled;
    logic [3:0]       occupied;
    logic [3:0]       eff;
    logic [3:0]       now_m [TYPES];
    logic [3:0]       old_m [TYPES];
    logic [NPOS-1:0]  now_p;
    logic [NPOS-1:0]  old_p;
    logic [NPOS-1:0]  raised_p;
    logic [CNT_W-1:0] raised_cnt;
    logic [7:0]       colours;

    assign in_stall = qstat.full;
    assign accept   = in_valid && !qstat.full;
    assign row_ok   = (row != '0) && ({1'b0, row} <= ROWS_L);
    assign rix      = row - ROW_W'(1);
    assign idx      = rix[RIX_W-1:0];
    assign push     = accept && !func && row_ok;

    assign buckled  = ~belt_mask;
    assign occupied = ~seat_empty;
    assign eff      = frozen_reg ? saved_reg[idx] : status_pins;

    assign now_m[0] = buckled & seat_empty;
    assign now_m[1] = occupied & eff;
    assign now_m[2] = buckled & eff;
    assign old_m[0] = bes_reg[idx];
    assign old_m[1] = oi_reg[idx];
    assign old_m[2] = bi_reg[idx];

    always_comb
    begin
        for (int s = 0; s < SEATS; s++)
        begin
            for (int t = 0; t < TYPES; t++)
            begin
                now_p[s*TYPES+t] = now_m[t][s];
                old_p[s*TYPES+t] = old_m[t][s];
            end
            colours[2*s+1] = buckled[s];
            colours[2*s]   = ~(seat_empty[s] ^ buckled[s]);
        end
    end

    assign raised_p = now_p & ~old_p;

    always_comb
    begin
        raised_cnt = '0;
        for (int p = 0; p < NPOS; p++)
        begin
            raised_cnt = raised_cnt + CNT_W'(raised_p[p]);
        end
    end

    always_comb
    begin
        job.rix        = rix;
        job.change     = now_p ^ old_p;
        job.now        = now_p;
        job.colours    = colours;
        job.seats      = seat_empty;
        job.buckled    = buckled;
        job.eff        = eff;
        job.door       = door_open;
        job.syserr     = system_error;
        job.alarm      = |(occupied & belt_mask & ~status_pins);
        job.raised_cnt = raised_cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frozen_reg <= 1'b0;
            for (int r = 0; r < ROWS; r++)
            begin
                live_reg[r]  <= '0;
                saved_reg[r] <= '0;
                bes_reg[r]   <= '0;
                oi_reg[r]    <= '0;
                bi_reg[r]    <= '0;
            end
        end
        else if (accept)
        begin
            if (func)
            begin
                if (!frozen_reg)
                begin
                    frozen_reg <= 1'b1;
                    for (int r = 0; r < ROWS; r++)
                    begin
                        saved_reg[r] <= live_reg[r];
                    end
                end
            end
            else if (row_ok)
            begin
                live_reg[idx] <= status_pins;
                bes_reg[idx]  <= now_m[0];
                oi_reg[idx]   <= now_m[1];
                bi_reg[idx]   <= now_m[2];
            end
        end
    end

endmodule

// ===== design/sbrm_queue.sv =====
// sbrm_queue: short FIFO of classified row reports between front and back.
// Depends on sbrm_pkg.
module sbrm_queue #(
    parameter int DEPTH = sbrm_pkg::QDEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sbrm_pkg::job_t   wdata,
    input  logic             pop,
    output sbrm_pkg::job_t   head,
    output sbrm_pkg::qstat_t qstat
);
    import sbrm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] DEPTH_L  = CNT_QW'(DEPTH);

    job_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_QW-1:0] count_reg;
    logic [CNT_QW-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign qstat.full  = (count_reg == DEPTH_L);
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_QW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_L)
        else $error("queue count above depth");

    a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + CNT_QW'(1)))
        else $error("queue count not advanced on push");

endmodule

// ===== design/sbrm_back.sv =====
// sbrm_back: walks the change mask of the head report, emits events then the row report.
// Depends on sbrm_pkg.
module sbrm_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sbrm_pkg::job_t            head,
    input  sbrm_pkg::qstat_t          qstat,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                event_res,
    output logic [sbrm_pkg::ROW_W-1:0] row_index,
    output logic [1:0]                seat_index,
    output logic [7:0]                seat_colours,
    output logic [3:0]                occupied_raw,
    output logic [3:0]                buckled_bits,
    output logic [3:0]                status_used,
    output logic                      door_flag,
    output logic                      error_code,
    output logic                      unbuckled_alarm,
    output logic [sbrm_pkg::CNT_W-1:0] new_error_count,
    output logic                      last
);
    import sbrm_pkg::*;

    logic [NPOS-1:0]  done_reg;
    logic             out_valid_reg;
    logic [2:0]       event_reg;
    logic [ROW_W-1:0] row_reg;
    logic [1:0]       seat_reg;
    logic [7:0]       colours_reg;
    logic [3:0]       occ_reg;
    logic [3:0]       buck_reg;
    logic [3:0]       eff_reg;
    logic             door_reg;
    logic             err_reg;
    logic             alarm_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             last_reg;

    logic             advance;
    logic [NPOS-1:0]  rem;
    logic             found;
    logic [1:0]       sel_seat;
    logic [1:0]       sel_type;
    logic             sel_now;
    logic [NPOS-1:0]  sel_bit;

    assign advance = !qstat.empty && (!out_valid_reg || !out_stall);
    assign rem     = head.change & ~done_reg;
    assign pop     = advance && (rem == '0);

    always_comb
    begin
        found    = 1'b0;
        sel_seat = '0;
        sel_type = '0;
        sel_now  = 1'b0;
        sel_bit  = '0;
        for (int s = 0; s < SEATS; s++)
        begin
            for (int t = 0; t < TYPES; t++)
            begin
                if (!found && rem[s*TYPES+t])
                begin
                    found    = 1'b1;
                    sel_seat = 2'(s);
                    sel_type = 2'(t);
                    sel_now  = head.now[s*TYPES+t];
                    sel_bit  = NPOS'(1) << (s*TYPES+t);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            done_reg      <= found ? (done_reg | sel_bit) : '0;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            row_reg <= head.rix;
            if (found)
            begin
                event_reg   <= (sel_now ? EV_RAISE_BASE : EV_CLEAR_BASE) + {1'b0, sel_type};
                seat_reg    <= sel_seat;
                colours_reg <= '0;
                occ_reg     <= '0;
                buck_reg    <= '0;
                eff_reg     <= '0;
                door_reg    <= 1'b0;
                err_reg     <= 1'b0;
                alarm_reg   <= 1'b0;
                cnt_reg     <= '0;
                last_reg    <= 1'b0;
            end
            else
            begin
                event_reg   <= EV_REPORT;
                seat_reg    <= '0;
                colours_reg <= head.colours;
                occ_reg     <= head.seats;
                buck_reg    <= head.buckled;
                eff_reg     <= head.eff;
                door_reg    <= head.door;
                err_reg     <= head.syserr;
                alarm_reg   <= head.alarm;
                cnt_reg     <= head.raised_cnt;
                last_reg    <= 1'b1;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign event_res       = event_reg;
    assign row_index       = row_reg;
    assign seat_index      = seat_reg;
    assign seat_colours    = colours_reg;
    assign occupied_raw    = occ_reg;
    assign buckled_bits    = buck_reg;
    assign status_used     = eff_reg;
    assign door_flag       = door_reg;
    assign error_code      = err_reg;
    assign unbuckled_alarm = alarm_reg;
    assign new_error_count = cnt_reg;
    assign last            = last_reg;

    a_last_is_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (last_reg == (event_reg == EV_REPORT)))
        else $error("last flag does not match row report");

    a_done_subset: assert property (@(posedge clk) disable iff (!rst_n)
        !qstat.empty |-> ((done_reg & ~head.change) == '0))
        else $error("emitted bits outside head change mask");

endmodule
